[src/thread_table_random_scheduler_core_macros.svh]
// Assertion helpers for the scheduler core
`ifndef THREAD_TABLE_RANDOM_SCHEDULER_CORE_MACROS_SVH
`define THREAD_TABLE_RANDOM_SCHEDULER_CORE_MACROS_SVH

// check prop on every clock edge outside reset
`define TTRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check prop on every clock edge, reset included
`define TTRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/ttrs_pkg.sv]
`default_nettype none
package ttrs_pkg;

  typedef enum logic [1:0] {
    OP_CREATE   = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_FAULT    = 2'd2,
    OP_NOP      = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CREATED  = 3'd0,
    ST_FULL     = 3'd1,
    ST_STAY     = 3'd2,
    ST_SWITCHED = 3'd3,
    ST_FATAL    = 3'd4,
    ST_ZOMBIED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SLOT_UNUSED = 2'd0,
    SLOT_READY  = 2'd1,
    SLOT_ZOMBIE = 2'd2
  } slot_e;

  localparam int unsigned TidW  = 6;
  localparam int unsigned SeedW = 64;
  localparam logic [31:0] LcgMul    = 32'hdeadbeed;
  localparam logic [31:0] LcgAdd    = 32'h12345679;
  localparam logic [63:0] SeedReset = 64'hcafebabedeadbeef;

endpackage
`default_nettype wire

[src/ttrs_ram.sv]
`default_nettype none
module ttrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[src/ttrs_divider.sv]
`default_nettype none
// Restoring 64-bit by N-bit remainder unit, one quotient bit per cycle.
module ttrs_divider #(
  parameter int unsigned DivW = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [ttrs_pkg::SeedW-1:0] dividend_i,
  input  wire logic [DivW-1:0]          divisor_i,
  output logic                          done_o,
  output logic                          zero_o
);
  import ttrs_pkg::*;

  localparam int unsigned CntW = $clog2(SeedW + 1);

  logic [SeedW-1:0] num_q, num_d;
  logic [DivW:0]    rem_q, rem_d;
  logic [DivW-1:0]  den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DivW:0]    shifted;
  logic             done_d;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q[DivW-1:0], num_q[SeedW-1]};
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = CntW'(SeedW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[SeedW-2:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
      end else begin
        rem_d = shifted;
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_o <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign zero_o = (rem_q == '0);
endmodule
`default_nettype wire

[src/thread_table_random_scheduler_core.sv]
`default_nettype none
// Channel   Ports                                           Direction
// command   start_i, busy_o, opcode_i .. is_process_i       in
// result    done_o, status_o, result_tid_o, result_pid_o    out
//
// Create walks the slot table, one slot a cycle.
// Schedule: LCG step from two 32x32 partial products, then a walk over the
// slots, one slot a cycle, that pauses at each ready slot for a remainder
// pass in the divider before the result.
// Fault reads the slot pid and may run a schedule after it.
// Reset clears the slot table before the core goes idle; receiver never stalls.
module thread_table_random_scheduler_core #(
  parameter int unsigned THREAD_SLOTS = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [1:0]             opcode_i,
  input  wire logic [5:0]             target_tid_i,
  input  wire logic                   must_switch_i,
  input  wire logic                   has_parent_i,
  input  wire logic [5:0]             parent_tid_i,
  input  wire logic                   is_process_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [5:0]                  result_tid_o,
  output logic [5:0]                  result_pid_o
);
  import ttrs_pkg::*;

  `include "thread_table_random_scheduler_core_macros.svh"

  localparam int unsigned IdxW = $clog2(THREAD_SLOTS);
  localparam int unsigned CntW = $clog2(THREAD_SLOTS + 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CSCAN  = 13'b0000000000010,
    S_CRD    = 13'b0000000000100,
    S_CWAIT  = 13'b0000000001000,
    S_FRD    = 13'b0000000010000,
    S_FWAIT  = 13'b0000000100000,
    S_MUL    = 13'b0000001000000,
    S_WALK   = 13'b0000010000000,
    S_DIV    = 13'b0000100000000,
    S_DIVW   = 13'b0001000000000,
    S_FIN    = 13'b0010000000000,
    S_OUT    = 13'b0100000000000,
    S_CLR    = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   pick_q, pick_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [SeedW-1:0]  seed_q, seed_d;
  logic [SeedW-1:0]  acc_q, acc_d;
  logic [1:0]        mstep_q, mstep_d;
  logic [5:0]        tgt_q;
  logic              must_q, must_d;
  logic [IdxW-1:0]   skip_q, skip_d;
  logic              hasp_q, isp_q;
  logic [5:0]        par_q;
  logic [2:0]        st_q, st_d;
  logic [5:0]        rtid_q, rtid_d;
  logic [5:0]        rpid_q, rpid_d;
  logic              out_q;

  logic              slot_we;
  logic [IdxW-1:0]   slot_widx;
  slot_e             slot_wval;
  logic [IdxW-1:0]   slot_raddr;
  logic [1:0]        slot_rdata;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [5:0]        ram_wdata, ram_rdata;

  logic              div_start, div_done, div_zero;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic              accept;
  logic              tgt_in;
  logic              par_in;

  assign accept = start_i && !busy_o;
  assign tgt_in = ({26'd0, tgt_q} < 32'(THREAD_SLOTS));
  assign par_in = ({26'd0, par_q} < 32'(THREAD_SLOTS));

  // Read ahead: the slot at idx_q is on slot_rdata in the cycle after idx_d names it.
  assign slot_raddr = idx_d;

  ttrs_ram #(.Width(2), .Depth(THREAD_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_widx),
    .wdata_i (slot_wval),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  ttrs_ram #(.Width(6), .Depth(THREAD_SLOTS)) u_pid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ttrs_divider #(.DivW(CntW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (seed_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .zero_o     (div_zero)
  );

  // One 32x32 partial product per multiply step: lo*mul, hi*mul, then the add.
  always_comb begin
    mul_a = (mstep_q == 2'd0) ? seed_q[31:0] : seed_q[63:32];
    mul_b = LcgMul;
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    pick_d    = pick_q;
    cur_d     = cur_q;
    seed_d    = seed_q;
    acc_d     = acc_q;
    mstep_d   = mstep_q;
    must_d    = must_q;
    skip_d    = skip_q;
    st_d      = st_q;
    rtid_d    = rtid_q;
    rpid_d    = rpid_q;
    slot_we   = 1'b0;
    slot_widx = idx_q;
    slot_wval = SLOT_READY;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = 6'd0;
    ram_raddr = IdxW'(par_q);
    div_start = 1'b0;

    unique case (state_q)
      S_CLR: begin
        slot_we   = 1'b1;
        slot_wval = SLOT_UNUSED;
        if (32'(idx_q) == THREAD_SLOTS - 1) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          idx_d = '0;
          unique case (opcode_i)
            OP_CREATE:   state_d = S_CSCAN;
            OP_SCHEDULE: begin
              must_d  = must_switch_i;
              skip_d  = IdxW'(target_tid_i);
              if ({26'd0, target_tid_i} >= 32'(THREAD_SLOTS)) begin
                skip_d = '0;
              end
              mstep_d = 2'd0;
              state_d = S_MUL;
            end
            OP_FAULT:    state_d = S_FRD;
            default: begin
              st_d    = ST_STAY;
              rtid_d  = 6'(cur_q);
              rpid_d  = 6'd0;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_CSCAN: begin
        if (slot_rdata == SLOT_UNUSED) begin
          state_d = S_CRD;
        end else if (32'(idx_q) == THREAD_SLOTS - 1) begin
          st_d    = ST_FULL;
          rtid_d  = 6'd0;
          rpid_d  = 6'd0;
          state_d = S_OUT;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_CRD: state_d = S_CWAIT;
      S_CWAIT: begin
        if (isp_q) begin
          rpid_d = 6'(idx_q);
        end else if (hasp_q && par_in) begin
          rpid_d = ram_rdata;
        end else begin
          rpid_d = 6'd0;
        end
        ram_we    = 1'b1;
        ram_wdata = rpid_d;
        slot_we   = 1'b1;
        st_d      = ST_CREATED;
        rtid_d    = 6'(idx_q);
        state_d   = S_OUT;
      end
      S_FRD: begin
        ram_raddr = IdxW'(tgt_q);
        if (!tgt_in) begin
          st_d    = ST_ZOMBIED;
          rtid_d  = 6'd0;
          rpid_d  = 6'd0;
          state_d = S_OUT;
        end else begin
          state_d = S_FWAIT;
        end
      end
      S_FWAIT: begin
        rtid_d = 6'd0;
        rpid_d = 6'd0;
        if (ram_rdata == 6'd0) begin
          st_d    = ST_FATAL;
          state_d = S_OUT;
        end else if (IdxW'(tgt_q) == cur_q) begin
          slot_we   = 1'b1;
          slot_widx = IdxW'(tgt_q);
          slot_wval = SLOT_UNUSED;
          must_d    = 1'b1;
          skip_d    = cur_q;
          mstep_d   = 2'd0;
          state_d   = S_MUL;
        end else begin
          slot_we   = 1'b1;
          slot_widx = IdxW'(tgt_q);
          slot_wval = SLOT_ZOMBIE;
          st_d      = ST_ZOMBIED;
          state_d   = S_OUT;
        end
      end
      S_MUL: begin
        // seed*mul + add, low 64 bits: lo*m + (hi*m << 32) + add
        unique case (mstep_q)
          2'd0: begin
            acc_d   = mul_p;
            mstep_d = 2'd1;
          end
          2'd1: begin
            acc_d   = acc_q + {mul_p[31:0], 32'd0};
            mstep_d = 2'd2;
          end
          default: begin
            seed_d  = acc_q + {32'd0, LcgAdd};
            idx_d   = IdxW'(1);
            cnt_d   = '0;
            found_d = 1'b0;
            pick_d  = '0;
            state_d = S_WALK;
          end
        endcase
      end
      S_WALK: begin
        if (idx_q != skip_q && slot_rdata == SLOT_READY) begin
          cnt_d   = cnt_q + CntW'(1);
          state_d = S_DIV;
        end else if (32'(idx_q) == THREAD_SLOTS - 1) begin
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          if (div_zero) begin
            found_d = 1'b1;
            pick_d  = idx_q;
          end
          if (32'(idx_q) == THREAD_SLOTS - 1) begin
            state_d = S_FIN;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_WALK;
          end
        end
      end
      S_FIN: begin
        rpid_d = 6'd0;
        if (!found_q && (!must_q || cur_q == '0)) begin
          st_d   = ST_STAY;
          rtid_d = 6'(cur_q);
        end else begin
          cur_d  = found_q ? pick_q : '0;
          st_d   = ST_SWITCHED;
          rtid_d = 6'(cur_d);
        end
        state_d = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      idx_q   <= '0;
      cur_q   <= '0;
      seed_q  <= SeedReset;
      out_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cur_q   <= cur_d;
      seed_q  <= seed_d;
      out_q   <= (state_d == S_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    found_q <= found_d;
    pick_q  <= pick_d;
    acc_q   <= acc_d;
    mstep_q <= mstep_d;
    must_q  <= must_d;
    skip_q  <= skip_d;
    st_q    <= st_d;
    rtid_q  <= rtid_d;
    rpid_q  <= rpid_d;
    if (accept) begin
      tgt_q  <= target_tid_i;
      hasp_q <= has_parent_i;
      isp_q  <= is_process_i;
      par_q  <= parent_tid_i;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = out_q;
  assign status_o     = st_q;
  assign result_tid_o = rtid_q;
  assign result_pid_o = rpid_q;

  `TTRS_ASSERT(a_done_one_cycle, done_o |=> !done_o, "result strobe held two cycles")
  `TTRS_ASSERT(a_accept_busy, accept |=> busy_o, "accepted command did not raise busy")
  `TTRS_ASSERT(a_done_idle, done_o |=> !busy_o, "not ready after the result")
  `TTRS_ASSERT(a_status_range, done_o |-> (status_o <= ST_ZOMBIED), "status out of range")
  `TTRS_ASSERT(a_pid_zero, done_o && status_o != ST_CREATED |-> result_pid_o == 6'd0,
               "pid on non-create result")
  `TTRS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o, "result strobe after reset")
endmodule
`default_nettype wire

[sim/ttrs_checker.sv]
`default_nettype none
module ttrs_checker
  import ttrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [5:0]  target_tid_i,
  input  wire logic        must_switch_i,
  input  wire logic        has_parent_i,
  input  wire logic [5:0]  parent_tid_i,
  input  wire logic        is_process_i,
  input  wire logic        done_i,
  input  wire logic [2:0]  status_i,
  input  wire logic [5:0]  result_tid_i,
  input  wire logic [5:0]  result_pid_i,
  output int               mismatches_o,
  output int               pending_o,
  output logic [63:0]      pid_known_o,
  output logic [5:0]       current_tid_o
);

  typedef struct packed {
    status_e    status;
    logic [5:0] tid;
    logic [5:0] pid;
  } sched_result_t;

  slot_e         slots[64];
  logic [5:0]    pids[64];
  logic [5:0]    cur_tid;
  logic [63:0]   seed;
  sched_result_t expected_q[$];

  assign pending_o     = expected_q.size();
  assign current_tid_o = cur_tid;

  // Advance the LCG and pick a ready slot by reservoir sampling.
  task automatic pick_next(input logic [5:0] skip, input logic force_sw,
                           output sched_result_t res);
    logic [63:0] cnt;
    logic        found;
    logic [5:0]  pick;
    cnt   = 0;
    found = 1'b0;
    pick  = '0;
    seed  = seed * 64'(LcgMul) + 64'(LcgAdd);
    for (int i = 1; i < 64; i++) begin
      if (i != skip && slots[i] == SLOT_READY) begin
        cnt++;
        if (seed % cnt == 0) begin
          pick  = i[5:0];
          found = 1'b1;
        end
      end
    end
    if (!found && (!force_sw || cur_tid == 0)) begin
      res = '{ST_STAY, cur_tid, 6'd0};
    end else begin
      cur_tid = pick;
      res = '{ST_SWITCHED, pick, 6'd0};
    end
  endtask

  task automatic predict_transfer(output sched_result_t res);
    logic [5:0] pid;
    logic       placed;
    placed = 1'b0;
    case (opcode_e'(opcode_i))
      OP_CREATE: begin
        res = '{ST_FULL, 6'd0, 6'd0};
        for (int i = 0; i < 64; i++) begin
          if (!placed && slots[i] == SLOT_UNUSED) begin
            pid = '0;
            if (is_process_i) pid = i[5:0];
            else if (has_parent_i) pid = pids[parent_tid_i];
            pids[i]        = pid;
            pid_known_o[i] = 1'b1;
            slots[i]       = SLOT_READY;
            res            = '{ST_CREATED, i[5:0], pid};
            placed         = 1'b1;
          end
        end
      end
      OP_SCHEDULE: pick_next(target_tid_i, must_switch_i, res);
      OP_FAULT: begin
        if (pids[target_tid_i] == 0) begin
          res = '{ST_FATAL, 6'd0, 6'd0};
        end else if (target_tid_i == cur_tid) begin
          slots[target_tid_i] = SLOT_UNUSED;
          pick_next(cur_tid, 1'b1, res);
        end else begin
          slots[target_tid_i] = SLOT_ZOMBIE;
          res = '{ST_ZOMBIED, 6'd0, 6'd0};
        end
      end
      default: res = '{ST_STAY, cur_tid, 6'd0};
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t exp_res;
    if (!rst_ni) begin
      foreach (slots[i]) slots[i] = SLOT_UNUSED;
      foreach (pids[i]) pids[i] = '0;
      pid_known_o  = '0;
      cur_tid      = '0;
      seed         = SeedReset;
      mismatches_o = 0;
      expected_q.delete();
    end else begin
      if (start_i && !busy_i) begin
        predict_transfer(exp_res);
        expected_q.push_back(exp_res);
      end
      if (done_i) begin
        if (expected_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("unexpected result: status %0d tid %0d pid %0d",
                     status_i, result_tid_i, result_pid_i);
        end else begin
          exp_res = expected_q.pop_front();
          if (status_i !== exp_res.status || result_tid_i !== exp_res.tid ||
              result_pid_i !== exp_res.pid) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("mismatch: expected status %0d tid %0d pid %0d, got %0d %0d %0d",
                       exp_res.status, exp_res.tid, exp_res.pid,
                       status_i, result_tid_i, result_pid_i);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[sim/tb_top.sv]
`default_nettype none
module tb_top;
  import ttrs_pkg::*;

  localparam int NumRandom = 925;
  localparam int CycleLimit = 30_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  opcode_i = '0;
  logic [5:0]  target_tid_i = '0;
  logic        must_switch_i = 1'b0;
  logic        has_parent_i = 1'b0;
  logic [5:0]  parent_tid_i = '0;
  logic        is_process_i = 1'b0;
  logic        busy_o, done_o;
  logic [2:0]  status_o;
  logic [5:0]  result_tid_o, result_pid_o;
  int          mismatches, pending;
  logic [63:0] pid_known;
  logic [5:0]  cur_tid;
  int          idle_pct;
  int          cycles = 0;

  thread_table_random_scheduler_core dut (.*);

  ttrs_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .opcode_i, .target_tid_i,
    .must_switch_i, .has_parent_i, .parent_tid_i, .is_process_i,
    .done_i(done_o), .status_i(status_o), .result_tid_i(result_tid_o),
    .result_pid_i(result_pid_o), .mismatches_o(mismatches), .pending_o(pending),
    .pid_known_o(pid_known), .current_tid_o(cur_tid)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Hold start until the transfer, then drop it.
  task automatic issue(input opcode_e op, input logic [5:0] tgt, input logic sw,
                       input logic hp, input logic [5:0] par, input logic proc);
    while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    @(posedge clk_i);
    start_i       <= 1'b1;
    opcode_i      <= op;
    target_tid_i  <= tgt;
    must_switch_i <= sw;
    has_parent_i  <= hp;
    parent_tid_i  <= par;
    is_process_i  <= proc;
    do @(posedge clk_i); while (busy_o);
    start_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [5:0] any_known_slot();
    logic [5:0] s;
    do s = 6'($urandom_range(0, 63)); while (!pid_known[s]);
    return s;
  endfunction

  task automatic random_item();
    int          r;
    logic [5:0]  tgt, par;
    logic        hp, proc;
    r    = $urandom_range(0, 99);
    hp   = 1'($urandom);
    proc = 1'($urandom);
    par  = 6'($urandom);
    tgt  = 6'($urandom);
    if (r < 35) begin
      if (hp && !proc) begin
        if (pid_known == 0) hp = 1'b0;
        else par = any_known_slot();
      end
      issue(OP_CREATE, tgt, 1'($urandom), hp, par, proc);
    end else if (r < 65 || pid_known == 0) begin
      if ($urandom_range(0, 1)) tgt = cur_tid;
      issue(OP_SCHEDULE, tgt, 1'($urandom), hp, par, proc);
    end else if (r < 92) begin
      tgt = (pid_known[cur_tid] && $urandom_range(0, 9) < 4) ? cur_tid : any_known_slot();
      issue(OP_FAULT, tgt, 1'($urandom), hp, par, proc);
    end else begin
      issue(OP_NOP, tgt, 1'($urandom), hp, par, proc);
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: process ids from self, none, and parent; schedules; faults; a nop
    issue(OP_SCHEDULE, 6'd0, 1'b1, 1'b0, 6'd0, 1'b0);
    issue(OP_CREATE, 6'd0, 1'b0, 1'b0, 6'd0, 1'b1);
    issue(OP_CREATE, 6'd63, 1'b0, 1'b0, 6'd63, 1'b0);
    issue(OP_CREATE, 6'd0, 1'b0, 1'b1, 6'd0, 1'b0);
    issue(OP_CREATE, 6'd0, 1'b0, 1'b0, 6'd0, 1'b1);
    issue(OP_CREATE, 6'd0, 1'b0, 1'b1, 6'd3, 1'b0);
    issue(OP_CREATE, 6'd0, 1'b0, 1'b1, 6'd4, 1'b1);
    issue(OP_SCHEDULE, 6'd63, 1'b0, 1'b0, 6'd0, 1'b0);
    issue(OP_SCHEDULE, 6'd3, 1'b1, 1'b1, 6'd63, 1'b1);
    issue(OP_FAULT, 6'd1, 1'b0, 1'b0, 6'd0, 1'b0);
    issue(OP_FAULT, 6'd4, 1'b0, 1'b0, 6'd0, 1'b0);
    issue(OP_FAULT, 6'd4, 1'b0, 1'b0, 6'd0, 1'b0);
    issue(OP_NOP, 6'd63, 1'b1, 1'b1, 6'd63, 1'b1);
    issue(OP_SCHEDULE, 6'd0, 1'b1, 1'b0, 6'd0, 1'b0);
    if (pid_known[cur_tid]) issue(OP_FAULT, cur_tid, 1'b0, 1'b0, 6'd0, 1'b0);
    issue(OP_SCHEDULE, 6'd0, 1'b0, 1'b0, 6'd0, 1'b0);

    for (int n = 0; n < NumRandom; n++) begin
      if (n % (NumRandom / 4) == 0) begin
        wait (pending == 0);
        @(negedge clk_i);
        case (n / (NumRandom / 4))
          0:       idle_pct = 0;
          1:       idle_pct = 60;
          2:       idle_pct = 0;
          default: idle_pct = 32;
        endcase
      end
      random_item();
    end

    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
